### sv/xlb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package xlb_pkg;

    localparam int WIDTH    = 32;
    localparam int IDX_W    = $clog2(WIDTH);
    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int ORDER_W  = 33;
    localparam int ANSWER_W = 32;
    localparam int RANK_W   = 6;

    typedef logic [WIDTH-1:0]  word_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [RANK_W-1:0] rank_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_MEMBER = 2'd1,
        CMD_MAXXOR = 2'd2,
        CMD_KTH    = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [VALUE_W-1:0]   value;
        logic [ORDER_W-1:0]   order;
    } req_t;

    typedef struct packed {
        logic [ANSWER_W-1:0]  answer;
        logic                 flag;
        logic [RANK_W-1:0]    rank_now;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_WALK = 2'd1,
        ST_DONE = 2'd2
    } walk_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } walk_stat_t;

endpackage

`default_nettype wire

### sv/xlb_slot_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module xlb_slot_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### sv/xlb_walk.sv
`timescale 1ns / 1ps
`default_nettype none

module xlb_walk (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire xlb_pkg::req_t      req,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output xlb_pkg::rsp_t           rsp,
    output xlb_pkg::walk_stat_t     stat
);

    import xlb_pkg::*;

    walk_state_t            state_reg, state_next;
    idx_t                   idx_reg, idx_next;
    cmd_t                   cmd_reg, cmd_next;
    word_t                  x_reg, x_next;
    word_t                  acc_reg, acc_next;
    logic [ORDER_W-1:0]     k_reg, k_next;
    rank_t                  left_reg, left_next;
    rank_t                  rank_reg, rank_next;
    logic                   flag_reg, flag_next;
    logic [WIDTH-1:0]       slot_vld_reg, slot_vld_next;
    logic                   rd_vld_reg;

    logic                   rd_en;
    idx_t                   rd_addr;
    word_t                  rd_data;
    logic                   wr_en;

    xlb_slot_ram #(
        .DATA_W (WIDTH),
        .DEPTH  (WIDTH)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (x_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        word_t              slot;
        word_t              y;
        word_t              a;
        rank_t              left_dec;
        logic [ORDER_W-1:0] half;
        logic               finish;

        // slots never written read as empty
        slot          = rd_vld_reg ? rd_data : '0;
        y             = x_reg ^ slot;
        a             = acc_reg;
        left_dec      = left_reg;
        half          = '0;
        finish        = 1'b0;

        state_next    = state_reg;
        idx_next      = idx_reg;
        cmd_next      = cmd_reg;
        x_next        = x_reg;
        acc_next      = acc_reg;
        k_next        = k_reg;
        left_next     = left_reg;
        rank_next     = rank_reg;
        flag_next     = flag_reg;
        slot_vld_next = slot_vld_reg;
        rd_en         = 1'b0;
        rd_addr       = idx_reg - idx_t'(1);
        wr_en         = 1'b0;
        req_ready     = 1'b0;
        rsp_valid     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    cmd_next   = req.cmd;
                    x_next     = WIDTH'(req.value);
                    k_next     = req.order;
                    acc_next   = '0;
                    left_next  = rank_reg;
                    flag_next  = 1'b0;
                    idx_next   = idx_t'(WIDTH - 1);
                    rd_en      = 1'b1;
                    rd_addr    = idx_t'(WIDTH - 1);
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                // prefetch the next lower slot while this one is processed
                rd_en = (idx_reg != '0);
                unique case (cmd_reg)
                    CMD_INSERT: begin
                        if (x_reg[idx_reg]) begin
                            if (slot == '0) begin
                                wr_en                  = 1'b1;
                                slot_vld_next[idx_reg] = 1'b1;
                                flag_next              = 1'b1;
                                rank_next              = rank_reg + rank_t'(1);
                                finish                 = 1'b1;
                            end else begin
                                x_next = y;
                            end
                        end
                    end
                    CMD_MEMBER: begin
                        if (y < x_reg) begin
                            x_next = y;
                        end
                    end
                    CMD_MAXXOR: begin
                        if (y > x_reg) begin
                            x_next = y;
                        end
                    end
                    CMD_KTH: begin
                        if (slot != '0) begin
                            if (left_reg != '0) begin
                                left_dec = left_reg - rank_t'(1);
                            end
                            left_next = left_dec;
                            if (acc_reg[idx_reg]) begin
                                a = acc_reg ^ slot;
                            end
                            half = ORDER_W'(1) << left_dec;
                            if (half >= k_reg) begin
                                acc_next = a;
                            end else begin
                                acc_next = a ^ slot;
                                k_next   = k_reg - half;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                if (finish || idx_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next = idx_reg - idx_t'(1);
                end
            end
            ST_DONE: begin
                rsp_valid = 1'b1;
                if (rsp_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        rsp.rank_now = rank_reg;
        rsp.answer   = '0;
        rsp.flag     = flag_reg;
        unique case (cmd_reg)
            CMD_INSERT: rsp.flag = flag_reg;
            CMD_MEMBER: rsp.flag = (x_reg == '0);
            CMD_MAXXOR: begin
                rsp.answer = ANSWER_W'(x_reg);
                rsp.flag   = 1'b0;
            end
            CMD_KTH: begin
                rsp.answer = ANSWER_W'(acc_reg);
                rsp.flag   = 1'b0;
            end
            default: rsp.flag = 1'b0;
        endcase
    end

    assign stat.busy = (state_reg != ST_IDLE);
    assign stat.done = (state_reg == ST_DONE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rank_reg     <= '0;
            slot_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rank_reg     <= rank_next;
            slot_vld_reg <= slot_vld_next;
            if (rd_en) begin
                rd_vld_reg <= slot_vld_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        cmd_reg  <= cmd_next;
        x_reg    <= x_next;
        acc_reg  <= acc_next;
        k_reg    <= k_next;
        left_reg <= left_next;
        flag_reg <= flag_next;
    end

endmodule

`default_nettype wire

### sv/xor_linear_basis_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// GF(2) linear basis of 32-bit words, one slot per leading bit, held in a
// 32-entry single-port-read slot memory. Each request (insert, membership
// test, maximum xor, kth smallest) walks the slots from the top bit down,
// one slot per cycle, with the next slot read ahead of the current one.
// The first read goes out in the accepting cycle, then come the 32 slot steps
// and the hand-off into the output register. An insert stops at the slot it
// fills and is done sooner. One request is worked on at a time; the next is
// taken in the cycle after the hand-off, and a result held back by m_ready
// stalls the input for as long as it is held.
module xor_linear_basis_engine (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire xlb_pkg::req_t  s_req,
    output logic                m_valid,
    input  wire logic           m_ready,
    output xlb_pkg::rsp_t       m_rsp
);

    import xlb_pkg::*;

    logic        walk_rsp_valid;
    logic        walk_rsp_ready;
    rsp_t        walk_rsp;
    walk_stat_t  walk_stat;
    logic        m_valid_reg;
    rsp_t        m_rsp_reg;

    xlb_walk u_walk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (s_req),
        .rsp_valid (walk_rsp_valid),
        .rsp_ready (walk_rsp_ready),
        .rsp       (walk_rsp),
        .stat      (walk_stat)
    );

    assign walk_rsp_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (walk_rsp_ready) begin
            m_valid_reg <= walk_rsp_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (walk_rsp_ready && walk_rsp_valid) begin
            m_rsp_reg <= walk_rsp;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

`ifndef SYNTHESIS
    a_no_accept_while_done: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_stat.done |-> !s_ready)
        else $error("request accepted while a result is pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> walk_stat.busy)
        else $error("walker not busy after request");

    a_flag_answer_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rsp.flag |-> m_rsp.answer == '0)
        else $error("flag set together with nonzero answer");

    a_rank_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_rsp.rank_now <= RANK_W'(WIDTH))
        else $error("rank exceeds word width");
`endif

endmodule

`default_nettype wire

### verif/tb_xor_linear_basis_engine.sv
`timescale 1ns / 1ps

module tb_xor_linear_basis_engine;
    import xlb_pkg::*;

    localparam int RANDOM_REQS = 1630;
    localparam int CALM_FROM   = 20000;
    localparam int CALM_TO     = 32000;
    localparam int HOLD_AT     = 6000;
    localparam int HOLD_LEN    = 400;

    logic  aclk = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    req_t  s_req = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    rsp_t  m_rsp;

    req_t  req_backlog_q[$];
    rsp_t  rsp_due_q[$];
    logic [31:0] inserted_words[$];

    // basis as the engine should hold it
    logic [31:0] basis_slot_m[WIDTH];
    logic [5:0]  basis_rank_m;

    int cycle_no = 0;
    int err_count = 0;
    int hold_left = 0;

    xor_linear_basis_engine DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic logic basis_insert(input logic [31:0] w);
        logic [31:0] x;
        logic        grew;
        x = w;
        grew = 1'b0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if (!grew && x[i]) begin
                if (basis_slot_m[i] == '0) begin
                    basis_slot_m[i] = x;
                    basis_rank_m++;
                    grew = 1'b1;
                end else begin
                    x ^= basis_slot_m[i];
                end
            end
        end
        return grew;
    endfunction

    function automatic logic in_span(input logic [31:0] w);
        logic [31:0] x;
        x = w;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if ((x ^ basis_slot_m[i]) < x) x = x ^ basis_slot_m[i];
        end
        return x == '0;
    endfunction

    function automatic logic [31:0] max_xor(input logic [31:0] w);
        logic [31:0] x;
        x = w;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if ((x ^ basis_slot_m[i]) > x) x = x ^ basis_slot_m[i];
        end
        return x;
    endfunction

    // walk filled slots from the top, taking the upper half whenever k lies past it
    function automatic logic [31:0] kth_smallest(input logic [32:0] order);
        logic [63:0] k;
        logic [63:0] half;
        logic [31:0] acc;
        int          left;
        k = {31'd0, order};
        acc = '0;
        left = basis_rank_m;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if (basis_slot_m[i] != '0) begin
                if (left > 0) left--;
                if (acc[i]) acc ^= basis_slot_m[i];
                half = 64'd1 << left;
                if (half < k) begin
                    acc ^= basis_slot_m[i];
                    k -= half;
                end
            end
        end
        return acc;
    endfunction

    task automatic predict_request(input req_t r);
        rsp_t p;
        p = '0;
        case (r.cmd)
            CMD_INSERT: p.flag = basis_insert(r.value);
            CMD_MEMBER: p.flag = in_span(r.value);
            CMD_MAXXOR: p.answer = max_xor(r.value);
            default:    p.answer = kth_smallest(r.order);
        endcase
        p.rank_now = basis_rank_m;
        rsp_due_q = {rsp_due_q, p};
    endtask

    task automatic queue_request(input cmd_t c, input logic [31:0] v,
                                 input logic [32:0] k);
        req_t r;
        r.cmd = c;
        r.value = v;
        r.order = k;
        req_backlog_q = {req_backlog_q, r};
        if (c == CMD_INSERT && v != '0) inserted_words = {inserted_words, v};
    endtask

    // xor of a few earlier inserts: always inside the span
    function automatic logic [31:0] span_word();
        logic [31:0] w;
        w = '0;
        if (inserted_words.size() > 0) begin
            repeat ($urandom_range(1, 4))
                w ^= inserted_words[$urandom_range(0, inserted_words.size() - 1)];
        end
        return w;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_request(s_req);
            if (!s_valid || s_ready) begin
                if (req_backlog_q.size() > 0 &&
                    ((cycle_no >= CALM_FROM && cycle_no < CALM_TO) ||
                     $urandom_range(0, 99) >= 37)) begin
                    s_valid <= 1'b1;
                    s_req <= req_backlog_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and result-side back-pressure
    always @(posedge aclk) begin
        rsp_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (rsp_due_q.size() == 0) begin
                    report_mismatch("unexpected result", m_rsp, '0);
                end else begin
                    want = rsp_due_q.pop_front();
                    if (m_rsp.answer !== want.answer)
                        report_mismatch("answer", m_rsp.answer, want.answer);
                    if (m_rsp.flag !== want.flag)
                        report_mismatch("flag", m_rsp.flag, want.flag);
                    if (m_rsp.rank_now !== want.rank_now)
                        report_mismatch("rank_now", m_rsp.rank_now, want.rank_now);
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else if (cycle_no == HOLD_AT) begin
                hold_left <= HOLD_LEN;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (cycle_no >= CALM_FROM && cycle_no < CALM_TO) ||
                           ($urandom_range(0, 99) >= 37);
            end
        end
    end

    initial begin
        cmd_t        c;
        logic [31:0] v;
        logic [32:0] k;
        for (int i = 0; i < WIDTH; i++) basis_slot_m[i] = '0;
        basis_rank_m = '0;

        // empty basis
        queue_request(CMD_MAXXOR, 32'hA5A5_A5A5, '0);
        queue_request(CMD_KTH, '0, 33'd0);
        queue_request(CMD_KTH, '0, 33'h1_FFFF_FFFF);
        queue_request(CMD_MEMBER, 32'h0, '0);
        queue_request(CMD_MEMBER, 32'hFFFF_FFFF, '0);
        // zero, independent and dependent inserts
        queue_request(CMD_INSERT, 32'h0, '0);
        queue_request(CMD_INSERT, 32'hFFFF_FFFF, '0);
        queue_request(CMD_INSERT, 32'h8000_0000, '0);
        queue_request(CMD_INSERT, 32'h7FFF_FFFF, '0);
        queue_request(CMD_INSERT, 32'h0000_0001, '0);
        queue_request(CMD_INSERT, 32'h0001_0000, '0);
        queue_request(CMD_MEMBER, 32'h7FFF_FFFE, '0);
        queue_request(CMD_MEMBER, 32'h0000_0002, '0);
        queue_request(CMD_MEMBER, 32'h0, '0);
        queue_request(CMD_MAXXOR, 32'h0, '0);
        queue_request(CMD_MAXXOR, 32'hFFFF_FFFF, '0);
        // rank is four here
        queue_request(CMD_KTH, '0, 33'd0);
        queue_request(CMD_KTH, '0, 33'd1);
        queue_request(CMD_KTH, '0, 33'd2);
        queue_request(CMD_KTH, '0, 33'd16);
        queue_request(CMD_KTH, '0, 33'd17);
        queue_request(CMD_KTH, '0, 33'h1_0000_0000);

        for (int n = 0; n < RANDOM_REQS; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: c = CMD_INSERT;
                3, 4:    c = CMD_MEMBER;
                5, 6:    c = CMD_MAXXOR;
                default: c = CMD_KTH;
            endcase
            v = $urandom();
            k = {1'($urandom_range(0, 1)), 32'($urandom())};
            case (c)
                CMD_INSERT: begin
                    // mostly dependent words so the rank climbs slowly
                    if (inserted_words.size() == 0 || $urandom_range(0, 99) < 9)
                        v = $urandom() >> $urandom_range(0, 31);
                    else
                        v = span_word();
                end
                CMD_MEMBER: begin
                    if ($urandom_range(0, 1) == 0) v = span_word();
                    else if ($urandom_range(0, 3) == 0) v = v >> $urandom_range(0, 31);
                end
                CMD_MAXXOR: begin
                    if ($urandom_range(0, 7) == 0) v = '0;
                end
                default: begin
                    case ($urandom_range(0, 2))
                        0: k = 33'($urandom_range(0, 64));
                        1: k = (33'd1 << $urandom_range(0, 32)) +
                               33'($urandom_range(0, 2)) - 33'd1;
                        default: ;
                    endcase
                end
            endcase
            queue_request(c, v, k);
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        wait (req_backlog_q.size() == 0 && !s_valid);
        wait (rsp_due_q.size() == 0);
        repeat (80) @(posedge aclk);
        if (err_count == 0 && rsp_due_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout at %0t", $realtime);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### xor_linear_basis_engine.f
sv/xlb_pkg.sv
sv/xlb_slot_ram.sv
sv/xlb_walk.sv
sv/xor_linear_basis_engine.sv
verif/tb_xor_linear_basis_engine.sv
